// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at the same edge.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

// File: rtl/core/rbp_pkg.sv
// ----------------------------------------------------------------------------
// rbp_pkg
// Types, codes and widths shared by the ReLU bound propagator.
// ----------------------------------------------------------------------------
`default_nettype none

package rbp_pkg;

  // Widths of the bound values, the tolerance and the register port.
  localparam int BOUND_WIDTH = 32;
  localparam int TOL_WIDTH   = 16;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;

  typedef logic signed [BOUND_WIDTH-1:0] bound_t;

  localparam bound_t BOUND_MAX = {1'b0, {(BOUND_WIDTH-1){1'b1}}};
  localparam bound_t BOUND_MIN = {1'b1, {(BOUND_WIDTH-1){1'b0}}};
  localparam bound_t BOUND_ZERO = '0;

  // Variable selector codes.
  localparam logic [1:0] VAR_B   = 2'd0;
  localparam logic [1:0] VAR_F   = 2'd1;
  localparam logic [1:0] VAR_AUX = 2'd2;

  // Notice and tightening kinds.
  localparam logic CMD_LOWER  = 1'b0;
  localparam logic CMD_UPPER  = 1'b1;
  localparam logic KIND_LOWER = 1'b0;
  localparam logic KIND_UPPER = 1'b1;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_AUX_IN_USE = 2'd0;
  localparam logic [1:0] REG_CONSTR_EN  = 2'd1;
  localparam logic [1:0] REG_TOLERANCE  = 2'd2;

  typedef enum logic [1:0] {
    PH_NOT_FIXED = 2'd0,
    PH_ACTIVE    = 2'd1,
    PH_INACTIVE  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EVAL   = 2'd1,
    ST_SECOND = 2'd2
  } state_e;

  typedef struct packed {
    logic                 aux_in_use;
    logic                 constraint_enabled;
    logic [TOL_WIDTH-1:0] tolerance;
  } cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic latch;        // capture the incoming notice
    logic eval_load;    // commit the bound update and load the first result
    logic load_second;  // load the second result
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic two_results;
  } dp_status_t;

  typedef struct packed {
    logic       has;
    logic [1:0] tvar;
    logic       kind;
    bound_t     value;
  } tight_t;

  typedef struct packed {
    tight_t     tight;
    logic       accepted;
    logic [1:0] phase;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/rbp_in_if.sv
// ----------------------------------------------------------------------------
// rbp_in_if
// Notice channel: valid/ready handshake with the bound notice payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbp_in_if
  import rbp_pkg::*;
();
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [1:0] var_sel;
  bound_t     bound;

  modport source (output valid, output cmd, output var_sel, output bound, input ready);
  modport sink   (input valid, input cmd, input var_sel, input bound, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rbp_out_if.sv
// ----------------------------------------------------------------------------
// rbp_out_if
// Result channel: valid/ready handshake with the tightening result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbp_out_if
  import rbp_pkg::*;
();
  logic       valid;
  logic       ready;
  logic       has_tightening;
  logic [1:0] tight_var;
  logic       tight_kind;
  bound_t     tight_value;
  logic       accepted;
  logic [1:0] phase;
  logic       last;

  modport source (
    output valid, output has_tightening, output tight_var, output tight_kind,
    output tight_value, output accepted, output phase, output last, input ready
  );
  modport sink (
    input valid, input has_tightening, input tight_var, input tight_kind,
    input tight_value, input accepted, input phase, input last, output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/relu_bound_propagator.sv
// ----------------------------------------------------------------------------
// relu_bound_propagator
// Bound propagation for one ReLU constraint f = max(b, 0) with optional
// auxiliary aux = f - b.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                       Payload
// in_i      sink       valid & ready                   cmd, var_sel, bound
// out_o     source     valid & ready                   tightening, accepted,
//                                                      phase, last
// apb       slave      psel & penable & pwrite         register write/read
//
// A notice is captured in ST_IDLE; in ST_EVAL the tighter test and bound
// update run in the datapath and the first result is loaded, and a notice
// that causes two results loads the second one in ST_SECOND.
// The next notice is taken while the last result still sits in the output
// register. Results stall in that register while out_o.ready is low.
// Reset clears the valid bits of the stored bounds and the phase; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module relu_bound_propagator
  import rbp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  rbp_in_if.sink                     in_i,
  rbp_out_if.source                  out_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  out_item_t  item;

  rbp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rbp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .in_cmd_i     (in_i.cmd),
    .in_var_sel_i (in_i.var_sel),
    .in_bound_i   (in_i.bound),
    .status_o     (status),
    .out_item_o   (item)
  );

  // Result payload from the output register.
  assign out_o.has_tightening = item.tight.has;
  assign out_o.tight_var      = item.tight.tvar;
  assign out_o.tight_kind     = item.tight.kind;
  assign out_o.tight_value    = item.tight.value;
  assign out_o.accepted       = item.accepted;
  assign out_o.phase          = item.phase;
  assign out_o.last           = item.last;

  // A taken first result is followed at once by the final one.
  `ASSERT_NEXT(a_second_follows, clk_i, rst_ni,
               out_o.valid && out_o.ready && !out_o.last, out_o.valid && out_o.last)
  // While a notice can be taken, any waiting result is the final one.
  `ASSERT_IMP(a_idle_holds_last, clk_i, rst_ni, in_i.ready && out_o.valid, out_o.last)
  // A rejected notice never carries a tightening.
  `ASSERT_IMP(a_reject_no_tight, clk_i, rst_ni,
              out_o.valid && !out_o.accepted, !out_o.has_tightening && out_o.last)

endmodule

`default_nettype wire

// File: rtl/core/rbp_cfg.sv
// ----------------------------------------------------------------------------
// rbp_cfg
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module rbp_cfg
  import rbp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.aux_in_use         <= 1'b0;
      cfg_q.constraint_enabled <= 1'b1;
      cfg_q.tolerance          <= TOL_WIDTH'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_AUX_IN_USE: cfg_q.aux_in_use         <= pwdata[0];
        REG_CONSTR_EN:  cfg_q.constraint_enabled <= pwdata[0];
        REG_TOLERANCE:  cfg_q.tolerance          <= pwdata[TOL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_AUX_IN_USE: prdata[0] = cfg_q.aux_in_use;
      REG_CONSTR_EN:  prdata[0] = cfg_q.constraint_enabled;
      REG_TOLERANCE:  prdata[TOL_WIDTH-1:0] = cfg_q.tolerance;
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/rbp_ctrl.sv
// ----------------------------------------------------------------------------
// rbp_ctrl
// Sequencer: takes a notice, evaluates it, and hands out one or two results.
// ----------------------------------------------------------------------------
`default_nettype none

module rbp_ctrl
  import rbp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  dp_status_t      status_i,
  output ctrl_cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_valid_o = out_valid_q;
  // The output register can take a new item when empty or drained this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          cmd_o.eval_load = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = status_i.two_results ? ST_SECOND : ST_IDLE;
        end
      end
      ST_SECOND: begin
        if (out_free) begin
          cmd_o.load_second = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/rbp_dp.sv
// ----------------------------------------------------------------------------
// rbp_dp
// Datapath: stored bounds, phase, tighter test, derived tightenings and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbp_dp
  import rbp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  cfg_t            cfg_i,
  input  ctrl_cmd_t       cmd_i,
  input  wire logic       in_cmd_i,
  input  wire logic [1:0] in_var_sel_i,
  input  bound_t          in_bound_i,
  output dp_status_t      status_o,
  output out_item_t       out_item_o
);

  // Latched notice.
  logic       cmd_q;
  logic [1:0] sel_q;
  bound_t     bd_q;

  // Stored bounds and phase.
  bound_t     lower_val_q [3];
  bound_t     upper_val_q [3];
  logic [2:0] lower_known_q;
  logic [2:0] upper_known_q;
  phase_e     phase_q, phase_d;

  // Pending second result and output register.
  tight_t     second_q;
  out_item_t  out_q;

  logic                       sel_ok;
  logic                       known;
  bound_t                     stored;
  logic signed [BOUND_WIDTH:0] bd_ext, st_ext, tol_ext, diff;
  logic                       tighter, acc;
  logic                       pos, neg, zero, gt0, lt0;
  logic                       is_b, is_f, is_aux, aux;
  bound_t                     neg_bd;
  tight_t                     e0, e1;
  logic                       two;

  assign out_item_o = out_q;
  assign status_o.two_results = two;

  // Select the stored bound that the notice is compared against.
  always_comb begin
    sel_ok = 1'b1;
    known  = 1'b0;
    stored = BOUND_ZERO;
    case (sel_q)
      VAR_B, VAR_F, VAR_AUX: begin
        known  = (cmd_q == CMD_LOWER) ? lower_known_q[sel_q] : upper_known_q[sel_q];
        stored = (cmd_q == CMD_LOWER) ? lower_val_q[sel_q] : upper_val_q[sel_q];
      end
      default: sel_ok = 1'b0;
    endcase
  end

  // Tighter test: the difference must exceed the tolerance.
  always_comb begin
    bd_ext  = {bd_q[BOUND_WIDTH-1], bd_q};
    st_ext  = {stored[BOUND_WIDTH-1], stored};
    tol_ext = {{(BOUND_WIDTH+1-TOL_WIDTH){1'b0}}, cfg_i.tolerance};
    diff    = (cmd_q == CMD_LOWER) ? (bd_ext - st_ext) : (st_ext - bd_ext);
    tighter = diff > tol_ext;
    acc     = sel_ok && (!known || tighter);
  end

  // Sign tests and saturating negation of the notice value.
  always_comb begin
    pos    = bd_ext > tol_ext;
    neg    = bd_ext < -tol_ext;
    zero   = !pos && !neg;
    gt0    = !bd_q[BOUND_WIDTH-1] && (bd_q != BOUND_ZERO);
    lt0    = bd_q[BOUND_WIDTH-1];
    neg_bd = (bd_q == BOUND_MIN) ? BOUND_MAX : -bd_q;
    is_b   = sel_q == VAR_B;
    is_f   = sel_q == VAR_F;
    is_aux = sel_q == VAR_AUX;
    aux    = cfg_i.aux_in_use;
  end

  // Phase update and derived tightenings for an accepted notice.
  always_comb begin
    phase_d = phase_q;
    e0      = '0;
    e1      = '0;
    if (acc) begin
      if (cmd_q == CMD_LOWER) begin
        if (is_f && pos) begin
          phase_d = PH_ACTIVE;
        end else if (is_b && !neg) begin
          phase_d = PH_ACTIVE;
        end else if (aux && is_aux && pos) begin
          phase_d = PH_INACTIVE;
        end
        if (cfg_i.constraint_enabled) begin
          if ((is_f || is_b) && gt0) begin
            e0 = '{has: 1'b1, tvar: (is_f ? VAR_B : VAR_F), kind: KIND_LOWER, value: bd_q};
            if (aux) begin
              e1 = '{has: 1'b1, tvar: VAR_AUX, kind: KIND_UPPER, value: BOUND_ZERO};
            end
          end else if (aux && is_b && zero) begin
            e0 = '{has: 1'b1, tvar: VAR_AUX, kind: KIND_UPPER, value: BOUND_ZERO};
          end else if (aux && is_aux && gt0) begin
            e0 = '{has: 1'b1, tvar: VAR_B, kind: KIND_UPPER, value: neg_bd};
            e1 = '{has: 1'b1, tvar: VAR_F, kind: KIND_UPPER, value: BOUND_ZERO};
          end else if (aux && is_b && lt0) begin
            e0 = '{has: 1'b1, tvar: VAR_AUX, kind: KIND_UPPER, value: neg_bd};
          end else if (is_f && lt0) begin
            e0 = '{has: 1'b1, tvar: VAR_F, kind: KIND_LOWER, value: BOUND_ZERO};
          end
        end
      end else begin
        if ((is_f || is_b) && !pos) begin
          phase_d = PH_INACTIVE;
        end
        if (aux && is_aux && zero) begin
          phase_d = PH_ACTIVE;
        end
        if (cfg_i.constraint_enabled) begin
          if (is_f) begin
            e0 = '{has: 1'b1, tvar: VAR_B, kind: KIND_UPPER, value: bd_q};
          end else if (is_b) begin
            if (!pos) begin
              e0 = '{has: 1'b1, tvar: VAR_F, kind: KIND_UPPER, value: BOUND_ZERO};
              if (aux) begin
                e1 = '{has: 1'b1, tvar: VAR_AUX, kind: KIND_LOWER, value: neg_bd};
              end
            end else begin
              e0 = '{has: 1'b1, tvar: VAR_F, kind: KIND_UPPER, value: bd_q};
            end
          end else if (aux && is_aux) begin
            e0 = '{has: 1'b1, tvar: VAR_B, kind: KIND_LOWER, value: neg_bd};
          end
        end
      end
    end
    two = e1.has;
  end

  // Notice capture and stored bound values (no reset: read only when known).
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q <= in_cmd_i;
      sel_q <= in_var_sel_i;
      bd_q  <= in_bound_i;
    end
    if (cmd_i.eval_load && acc) begin
      for (int i = 0; i < 3; i++) begin
        if (sel_q == 2'(i)) begin
          if (cmd_q == CMD_LOWER) begin
            lower_val_q[i] <= bd_q;
          end else begin
            upper_val_q[i] <= bd_q;
          end
        end
      end
    end
    if (cmd_i.eval_load) begin
      second_q       <= e1;
      out_q.tight    <= e0;
      out_q.accepted <= acc;
      out_q.phase    <= phase_d;
      out_q.last     <= !two;
    end else if (cmd_i.load_second) begin
      out_q.tight <= second_q;
      out_q.last  <= 1'b1;
    end
  end

  // Valid bits and phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_known_q <= '0;
      upper_known_q <= '0;
      phase_q       <= PH_NOT_FIXED;
    end else if (cmd_i.eval_load) begin
      phase_q <= phase_d;
      if (acc) begin
        if (cmd_q == CMD_LOWER) begin
          lower_known_q[sel_q] <= 1'b1;
        end else begin
          upper_known_q[sel_q] <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire
